/* rtl/core/msequence_walsh_permuter_defines.svh */
// assertion macros for the m-sequence permuter
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef MSEQUENCE_WALSH_PERMUTER_DEFINES_SVH
`define MSEQUENCE_WALSH_PERMUTER_DEFINES_SVH

`ifndef SYNTH

// clocked property, skipped while reset is low
`define MWP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expression that must never be true
`define MWP_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`else

`define MWP_ASSERT(label, prop, msg)

`define MWP_NEVER(label, expr, msg)

`endif

`endif

/* rtl/core/mwp_pkg.sv */
// types and constants for the m-sequence permuter
// no dependencies
package mwp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 10;
    localparam int ORDER_W    = 4;
    localparam int TAP_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [ORDER_W-1:0] SEQ_ORDER_RST = 4'd10;
    localparam logic [TAP_W-1:0]   TAP_MASK_RST  = 10'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK  = 1'd1;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    position;
    } t_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] read_data;
        logic                frame_complete;
    } t_rsp;

endpackage

/* rtl/core/msequence_walsh_permuter.sv */
// m-sequence permuting frame buffer: loads samples at generator positions, reads by position
// depends on mwp_pkg and msequence_walsh_permuter_defines.svh
// a read request's result is registered and appears in the cycle after acceptance; loads give none
// throughput: one request per cycle, busy stays low; buffer is a single-port memory
// reset (synchronous, active low): generator to 1, load count and frame flag cleared,
// config to seq_order 10 and tap_mask 0; the buffer is not cleared
// results carry a one-cycle strobe and cannot be held off by the receiver
`include "msequence_walsh_permuter_defines.svh"

module msequence_walsh_permuter #(
    parameter int MAX_ORDER  = 10,
    parameter int DATA_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mwp_pkg::t_req                     i_req,
    output logic                              o_done,
    output mwp_pkg::t_rsp                     o_rsp,
    input  logic                              i_cfg_we,
    input  logic [mwp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mwp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH = 1 << MAX_ORDER;
    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int CNT_W = MAX_ORDER + 1;

    // config registers
    logic [mwp_pkg::ORDER_W-1:0] r_seq_order;
    logic [mwp_pkg::TAP_W-1:0]   r_tap_mask;

    // sequencing state
    logic [MAX_ORDER-1:0] r_gen, n_gen;
    logic [CNT_W-1:0]     r_load_cnt, n_load_cnt;
    logic                 r_frame_done, n_frame_done;

    // result stage
    logic                  r_rsp_valid;
    logic                  r_rsp_flag;
    logic [DATA_WIDTH-1:0] r_mem_q;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic                  w_accept;
    logic                  w_load;
    logic [ORD_W-1:0]      w_ord;
    logic [CNT_W-1:0]      w_len;
    logic [CNT_W-1:0]      w_len_m1;
    logic [MAX_ORDER-1:0]  w_omask;
    logic [MAX_ORDER-1:0]  w_tap;
    logic [MAX_ORDER-1:0]  w_gen_m;
    logic                  w_fb;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic [MAX_ORDER-1:0]  w_addr;
    logic [DATA_WIDTH-1:0] w_wdata;

    logic [MAX_ORDER+mwp_pkg::TAP_W-1:0]       w_tap_pad;
    logic [MAX_ORDER+mwp_pkg::POS_W-1:0]       w_pos_pad;
    logic [DATA_WIDTH+mwp_pkg::SAMPLE_W-1:0]   w_sample_pad;
    logic [DATA_WIDTH+mwp_pkg::SAMPLE_W-1:0]   w_q_pad;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_req.op == mwp_pkg::OP_LOAD);

    // zero-extend then cut to the internal widths
    assign w_tap_pad    = {{MAX_ORDER{1'b0}}, r_tap_mask};
    assign w_tap        = w_tap_pad[MAX_ORDER-1:0];
    assign w_pos_pad    = {{MAX_ORDER{1'b0}}, i_req.position};
    assign w_sample_pad = {{DATA_WIDTH{1'b0}}, i_req.sample};
    assign w_wdata      = w_sample_pad[DATA_WIDTH-1:0];
    assign w_q_pad      = {{mwp_pkg::SAMPLE_W{1'b0}}, r_mem_q};

    // order clamped to 1..MAX_ORDER
    always_comb begin
        if (r_seq_order == '0) begin
            w_ord = ORD_W'(1);
        end else if (int'(r_seq_order) > MAX_ORDER) begin
            w_ord = ORD_W'(MAX_ORDER);
        end else begin
            w_ord = ORD_W'(r_seq_order);
        end
    end

    assign w_len     = CNT_W'(1) << w_ord;
    assign w_len_m1  = w_len - CNT_W'(1);
    assign w_omask   = w_len_m1[MAX_ORDER-1:0];
    assign w_gen_m   = r_gen & w_omask;
    assign w_fb      = ^(w_gen_m & w_tap);
    assign w_cnt_inc = r_load_cnt + CNT_W'(1);

    always_comb begin
        n_gen        = r_gen;
        n_load_cnt   = r_load_cnt;
        n_frame_done = r_frame_done;
        if (w_load) begin
            if (r_load_cnt == '0) begin
                n_gen        = MAX_ORDER'(1);
                n_frame_done = 1'b0;
            end else begin
                // shift right, feedback enters at the top active bit
                n_gen = (w_gen_m >> 1) | (MAX_ORDER'(w_fb) << (w_ord - ORD_W'(1)));
            end
            if (w_cnt_inc >= w_len) begin
                n_load_cnt   = '0;
                n_frame_done = 1'b1;
            end else begin
                n_load_cnt = w_cnt_inc;
            end
        end
    end

    // single memory port: load position or read position
    always_comb begin
        if (w_load) begin
            w_addr = (r_load_cnt == '0) ? '0 : w_gen_m;
        end else begin
            w_addr = w_pos_pad[MAX_ORDER-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_order <= mwp_pkg::SEQ_ORDER_RST;
            r_tap_mask  <= mwp_pkg::TAP_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mwp_pkg::CFG_SEQ_ORDER: r_seq_order <= i_cfg_data[mwp_pkg::ORDER_W-1:0];
                mwp_pkg::CFG_TAP_MASK:  r_tap_mask  <= i_cfg_data[mwp_pkg::TAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= MAX_ORDER'(1);
            r_load_cnt   <= '0;
            r_frame_done <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_gen        <= n_gen;
            r_load_cnt   <= n_load_cnt;
            r_frame_done <= n_frame_done;
            r_rsp_valid  <= w_accept && (i_req.op == mwp_pkg::OP_READ);
        end
    end

    // flag is sampled with the read request
    always_ff @(posedge i_clk) begin
        r_rsp_flag <= r_frame_done;
    end

    assign o_done              = r_rsp_valid;
    assign o_rsp.read_data     = w_q_pad[mwp_pkg::SAMPLE_W-1:0];
    assign o_rsp.frame_complete = r_rsp_flag;

    `MWP_ASSERT(a_read_gives_result, (w_accept && i_req.op == mwp_pkg::OP_READ) |=> o_done, "read request without result")
    `MWP_ASSERT(a_result_from_read, o_done |-> $past(w_accept && i_req.op == mwp_pkg::OP_READ), "result without read request")
    `MWP_NEVER(a_count_range, int'(r_load_cnt) >= DEPTH, "load count beyond buffer depth")
    `MWP_ASSERT(a_frame_start, (w_load && r_load_cnt == '0) |=> (!r_frame_done && r_gen == MAX_ORDER'(1)), "frame start did not reset generator and flag")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for msequence_walsh_permuter: directed and random load/read requests
// checked against a shadow frame buffer and generator; depends on mwp_pkg and the permuter rtl
module testbench;

    localparam int SAMPLE_W      = mwp_pkg::SAMPLE_W;
    localparam int POS_W         = mwp_pkg::POS_W;
    localparam int ORDER_W       = mwp_pkg::ORDER_W;
    localparam int TAP_W         = mwp_pkg::TAP_W;
    localparam int CFG_IDX_W     = mwp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = mwp_pkg::CFG_DATA_W;
    localparam int DEPTH         = 1 << POS_W;
    localparam int TOP_ORDER     = POS_W;
    localparam int SETTLE_CYCLES = 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 400;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    mwp_pkg::t_req         i_req      = '0;
    logic                  o_done;
    mwp_pkg::t_rsp         o_rsp;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the frame buffer, generator and config
    logic [SAMPLE_W-1:0] shadow_buf [DEPTH];
    bit                  filled [DEPTH];
    int                  filled_list [$];
    logic [POS_W-1:0]    gen_pos        = POS_W'(1);
    int                  loads_in_frame = 0;
    logic                frame_full     = 1'b0;
    logic [ORDER_W-1:0]  order_reg      = mwp_pkg::SEQ_ORDER_RST;
    logic [TAP_W-1:0]    taps_reg       = mwp_pkg::TAP_MASK_RST;
    mwp_pkg::t_rsp       pending_reads [$];

    int errors  = 0;
    int cycles  = 0;
    bit gapless = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    msequence_walsh_permuter #(
        .MAX_ORDER  (10),
        .DATA_WIDTH (16)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // order 0 behaves as 1, anything above the generator width saturates
    function automatic int active_order();
        if (order_reg == '0) return 1;
        if (int'(order_reg) > TOP_ORDER) return TOP_ORDER;
        return int'(order_reg);
    endfunction

    function automatic void track_request(mwp_pkg::t_req r);
        int               ord;
        logic [POS_W:0]   frame_len;
        logic [POS_W:0]   len_m1;
        logic [POS_W-1:0] omask;
        logic [POS_W-1:0] slot;
        logic [POS_W-1:0] fb_vec;
        mwp_pkg::t_rsp    word;
        ord       = active_order();
        frame_len = {{POS_W{1'b0}}, 1'b1} << ord;
        len_m1    = frame_len - {{POS_W{1'b0}}, 1'b1};
        omask     = len_m1[POS_W-1:0];
        if (r.op == mwp_pkg::OP_LOAD) begin
            if (loads_in_frame == 0) begin
                gen_pos    = POS_W'(1);
                frame_full = 1'b0;
                slot       = '0;
            end else begin
                slot          = gen_pos & omask;
                fb_vec        = '0;
                fb_vec[ord-1] = ^(gen_pos & taps_reg & omask);
                gen_pos       = ((gen_pos & omask) >> 1) | fb_vec;
            end
            shadow_buf[slot] = r.sample;
            if (!filled[slot]) begin
                filled[slot] = 1'b1;
                filled_list.push_back(int'(slot));
            end
            loads_in_frame++;
            if (loads_in_frame >= int'(frame_len)) begin
                loads_in_frame = 0;
                frame_full     = 1'b1;
            end
        end else begin
            word.read_data      = shadow_buf[r.position];
            word.frame_complete = frame_full;
            pending_reads.push_back(word);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        mwp_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected read result: read_data %h frame_complete %b",
                       o_rsp.read_data, o_rsp.frame_complete);
                errors++;
            end else begin
                want = pending_reads.pop_front();
                if (o_rsp.read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %h actual %h",
                           want.read_data, o_rsp.read_data);
                    errors++;
                end
                if (o_rsp.frame_complete !== want.frame_complete) begin
                    $error("frame_complete mismatch: expected %b actual %b",
                           want.frame_complete, o_rsp.frame_complete);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("msequence_walsh_permuter regression: fail");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [POS_W-1:0] pick_filled();
        return POS_W'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
    endfunction

    task automatic issue_request(mwp_pkg::t_req r);
        int g;
        g = gapless ? 0 : pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        track_request(r);
    endtask

    task automatic load_sample(logic [SAMPLE_W-1:0] s);
        mwp_pkg::t_req r;
        r.op       = mwp_pkg::OP_LOAD;
        r.sample   = s;
        r.position = POS_W'($urandom_range(0, DEPTH - 1));
        issue_request(r);
    endtask

    task automatic read_position(logic [POS_W-1:0] p);
        mwp_pkg::t_req r;
        r.op       = mwp_pkg::OP_READ;
        r.sample   = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        r.position = p;
        issue_request(r);
    endtask

    // hold off until every read result is back and the pipeline has settled
    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mwp_pkg::CFG_SEQ_ORDER) order_reg = data[ORDER_W-1:0];
        else                               taps_reg  = data[TAP_W-1:0];
    endtask

    // reset config: order 10, no taps, so the generator drops to zero after one shift
    task automatic test_reset_state();
        gapless = 1'b1;
        load_sample(16'hFFFF);
        load_sample(16'h0000);
        read_position(POS_W'(0));
        read_position(POS_W'(1));
        load_sample(16'h5A5A);
        read_position(POS_W'(0));
        gapless = 1'b0;
    endtask

    task automatic test_order_limits();
        // order 0 acts as 1; count already past the new length, so the frame closes
        set_register(mwp_pkg::CFG_SEQ_ORDER, 10'd0);
        load_sample(16'h8001);
        read_position(POS_W'(0));
        load_sample(16'h7FFE);
        read_position(POS_W'(0));
        load_sample(16'h1234);
        read_position(POS_W'(1));
        // order above the generator width saturates
        set_register(mwp_pkg::CFG_SEQ_ORDER, 10'd15);
        set_register(mwp_pkg::CFG_TAP_MASK, 10'h3FF);
        load_sample(16'hA5A5);
        load_sample(16'hC3C3);
        load_sample(16'h0F0F);
        read_position(pick_filled());
    endtask

    task automatic test_order_change_mid_frame();
        set_register(mwp_pkg::CFG_SEQ_ORDER, 10'd1);
        while (loads_in_frame != 0) load_sample(SAMPLE_W'($urandom_range(0, 65535)));
        set_register(mwp_pkg::CFG_SEQ_ORDER, 10'd3);
        set_register(mwp_pkg::CFG_TAP_MASK, 10'h006);
        repeat (5) load_sample(SAMPLE_W'($urandom_range(0, 65535)));
        read_position(pick_filled());
        // five loads already in, a frame of four ends on the next load
        set_register(mwp_pkg::CFG_SEQ_ORDER, 10'd2);
        load_sample(16'hBEEF);
        read_position(pick_filled());
        read_position(pick_filled());
    endtask

    task automatic test_full_frame();
        set_register(mwp_pkg::CFG_SEQ_ORDER, CFG_DATA_W'(TOP_ORDER));
        set_register(mwp_pkg::CFG_TAP_MASK,
                     CFG_DATA_W'($urandom_range(1, 1023)) | 10'h200);
        for (int n = 0; n < DEPTH; n++) begin
            gapless = (n < DEPTH / 2);
            load_sample(SAMPLE_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 7) == 0) read_position(pick_filled());
        end
        gapless = 1'b0;
        repeat (20) read_position(pick_filled());
    endtask

    task automatic test_random_traffic();
        int sent;
        int roll;
        int burst;
        logic [ORDER_W-1:0] ord;
        logic [TAP_W-1:0]   taps;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll < 7)       ord = ORDER_W'($urandom_range(1, 5));
            else if (roll == 7) ord = '0;
            else if (roll == 8) ord = ORDER_W'(TOP_ORDER);
            else                ord = ORDER_W'($urandom_range(TOP_ORDER + 1, 15));
            roll = $urandom_range(0, 9);
            if (roll < 2)       taps = '0;
            else if (roll == 2) taps = '1;
            else                taps = TAP_W'($urandom_range(0, 1023));
            // upper data bits are don't-care for the order register
            set_register(mwp_pkg::CFG_SEQ_ORDER, {6'($urandom_range(0, 63)), ord});
            if ($urandom_range(0, 3) != 0) set_register(mwp_pkg::CFG_TAP_MASK, taps);
            gapless = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(20, 50);
            repeat (burst) begin
                if (filled_list.size() == 0 || $urandom_range(0, 99) < 55)
                    load_sample(SAMPLE_W'($urandom_range(0, 65535)));
                else
                    read_position(pick_filled());
                if ($urandom_range(0, 19) == 0) wait_quiet();
                sent++;
            end
        end
        gapless = 1'b0;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_order_limits();
        test_order_change_mid_frame();
        test_full_frame();
        test_random_traffic();
        wait_quiet();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("msequence_walsh_permuter regression: pass");
        end else begin
            $display("msequence_walsh_permuter regression: fail");
        end
        $finish;
    end

endmodule
